// ===== rtl/core/mpd_pkg.sv =====
// Package for the MAC PDU deframer: constants, codes and shared types.
// No dependencies; used by every other file of the block but mpd_ifs.

package mpd_pkg;

   // Frame limits
   localparam int MAX_SDUS        = 8;
   localparam int MAX_FRAME_BYTES = 2048;
   // Frame byte counter saturates at MAX_FRAME_BYTES + 1
   localparam int FBC_W           = $clog2(MAX_FRAME_BYTES + 2);

   // Fixed header bytes
   localparam logic [7:0] HDR_MAGIC_B = 8'h42;
   localparam logic [7:0] HDR_MAGIC_M = 8'h4D;
   localparam logic [7:0] HDR_MAGIC_A = 8'h41;
   localparam logic [7:0] HDR_MAGIC_C = 8'h43;
   localparam logic [7:0] HDR_VERSION = 8'h01;

   // Header byte positions
   localparam logic [2:0] HPOS_MAGIC_B = 3'd0;
   localparam logic [2:0] HPOS_MAGIC_M = 3'd1;
   localparam logic [2:0] HPOS_MAGIC_A = 3'd2;
   localparam logic [2:0] HPOS_MAGIC_C = 3'd3;
   localparam logic [2:0] HPOS_VERSION = 3'd4;
   localparam logic [2:0] HPOS_COUNT   = 3'd5;
   localparam logic [2:0] HPOS_RSVD_0  = 3'd6;
   localparam logic [2:0] HPOS_RSVD_1  = 3'd7;

   // Subheader byte positions
   localparam logic [1:0] SPOS_CHANNEL = 2'd0;
   localparam logic [1:0] SPOS_ZERO    = 2'd1;
   localparam logic [1:0] SPOS_LEN_LO  = 2'd2;
   localparam logic [1:0] SPOS_LEN_HI  = 2'd3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_CHANNEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_CHANNEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SDU_CAPACITY = 2'd2;

   // Configuration reset values
   localparam logic [7:0] CTRL_CHANNEL_RST = 8'd0;
   localparam logic [7:0] DATA_CHANNEL_RST = 8'd1;
   localparam logic [3:0] SDU_CAPACITY_RST = 4'd8;

   // Parse phase, one-hot
   typedef enum logic [4:0] {
      PH_HEADER  = 5'b00001,
      PH_SUBHDR  = 5'b00010,
      PH_PAYLOAD = 5'b00100,
      PH_DONE    = 5'b01000,
      PH_ERROR   = 5'b10000
   } phase_type;

   // Frame status codes
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_HEADER     = 3'd1,
      ST_COUNT      = 3'd2,
      ST_TRUNC_SUB  = 3'd3,
      ST_BAD_SUB    = 3'd4,
      ST_TRAILING   = 3'd5
   } status_type;

   // Configuration as seen by the parser
   typedef struct packed {
      logic [7:0] ctrl_channel;
      logic [7:0] data_channel;
      logic [3:0] sdu_capacity;
   } cfg_type;

   // One input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_beat_type;

   // One result beat
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic [7:0]  channel_id;
      logic [2:0]  sdu_number;
      logic [15:0] byte_offset;
      logic        sdu_last_byte;
      logic        frame_done;
      logic [2:0]  status;
      logic [3:0]  sdu_count;
   } rsp_beat_type;

endpackage

// ===== rtl/core/mpd_ifs.sv =====
// Stream interfaces of the MAC PDU deframer: input byte channel and result channel.
// Both are valid/ready channels; no package dependency.

interface mpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface mpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic [7:0]  channel_id;
   logic [2:0]  sdu_number;
   logic [15:0] byte_offset;
   logic        sdu_last_byte;
   logic        frame_done;
   logic [2:0]  status;
   logic [3:0]  sdu_count;

   modport source (
      output valid, output payload_byte, output payload_valid, output channel_id,
      output sdu_number, output byte_offset, output sdu_last_byte, output frame_done,
      output status, output sdu_count, input ready
   );
   modport sink (
      input valid, input payload_byte, input payload_valid, input channel_id,
      input sdu_number, input byte_offset, input sdu_last_byte, input frame_done,
      input status, input sdu_count, output ready
   );
endinterface

// ===== rtl/core/mpd_in_stage.sv =====
// Input register of the MAC PDU deframer: holds one accepted byte beat.
// Depends on mpd_pkg and mpd_req_if.

module mpd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   mpd_req_if.sink               req_ch,
   input  logic                  advance,
   output logic                  beat_valid,
   output mpd_pkg::req_beat_type beat
);

   logic                  vld_ff;
   logic                  vld_in;
   mpd_pkg::req_beat_type beat_ff;
   logic                  take;

   // Room when empty or when the held beat moves on this cycle
   assign req_ch.ready = !vld_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff.data_byte <= req_ch.data_byte;
         beat_ff.frame_end <= req_ch.frame_end;
      end
   end

   assign beat_valid = vld_ff;
   assign beat       = beat_ff;

endmodule

// ===== rtl/core/mpd_parser.sv =====
// Frame parser of the MAC PDU deframer: parse state and the per-byte update.
// Depends on mpd_pkg.

module mpd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  mpd_pkg::cfg_type      cfg,
   input  mpd_pkg::req_beat_type beat,
   input  logic                  advance,
   output logic                  emit,
   output mpd_pkg::rsp_beat_type result
);

   localparam int FBC_W = mpd_pkg::FBC_W;

   mpd_pkg::phase_type  phase_ff, phase_in;
   logic [FBC_W-1:0]    fbc_ff, fbc_in;
   logic [7:0]          decl_ff, decl_in;
   logic [3:0]          sdu_ff, sdu_in;
   logic [1:0]          idx_ff, idx_in;
   logic [7:0]          chan_ff, chan_in;
   logic [7:0]          lenlo_ff, lenlo_in;
   logic [15:0]         rem_ff, rem_in;
   logic [15:0]         off_ff, off_in;
   logic                shbad_ff, shbad_in;
   mpd_pkg::status_type ferr_ff, ferr_in;

   logic [7:0]          b;
   logic                hdr_bad;
   logic [15:0]         sub_len;
   logic [3:0]          sdu_nx;
   mpd_pkg::status_type st;

   assign b       = beat.data_byte;
   assign sub_len = {b, lenlo_ff};
   assign sdu_nx  = sdu_ff + 4'd1;

   // A result leaves on every payload byte and on every frame end
   assign emit = (phase_ff == mpd_pkg::PH_PAYLOAD) || beat.frame_end;

   // Next state and result for the byte in the input register
   always_comb begin
      phase_in = phase_ff;
      fbc_in   = fbc_ff;
      decl_in  = decl_ff;
      sdu_in   = sdu_ff;
      idx_in   = idx_ff;
      chan_in  = chan_ff;
      lenlo_in = lenlo_ff;
      rem_in   = rem_ff;
      off_in   = off_ff;
      shbad_in = shbad_ff;
      ferr_in  = ferr_ff;
      hdr_bad  = 1'b0;
      st       = mpd_pkg::ST_OK;
      result   = '0;

      // Saturating frame length count
      if (fbc_ff <= FBC_W'(mpd_pkg::MAX_FRAME_BYTES)) begin
         fbc_in = fbc_ff + FBC_W'(1);
      end

      unique case (phase_ff)
         mpd_pkg::PH_HEADER: begin
            // Header phase never passes position 7
            unique case (fbc_ff[2:0])
               mpd_pkg::HPOS_MAGIC_B: hdr_bad = (b != mpd_pkg::HDR_MAGIC_B);
               mpd_pkg::HPOS_MAGIC_M: hdr_bad = (b != mpd_pkg::HDR_MAGIC_M);
               mpd_pkg::HPOS_MAGIC_A: hdr_bad = (b != mpd_pkg::HDR_MAGIC_A);
               mpd_pkg::HPOS_MAGIC_C: hdr_bad = (b != mpd_pkg::HDR_MAGIC_C);
               mpd_pkg::HPOS_VERSION: hdr_bad = (b != mpd_pkg::HDR_VERSION);
               mpd_pkg::HPOS_COUNT: begin
                  decl_in = b;
                  if ((b == 8'd0) || (b > 8'(mpd_pkg::MAX_SDUS)) ||
                      (b > {4'd0, cfg.sdu_capacity})) begin
                     if (ferr_ff == mpd_pkg::ST_OK) begin
                        ferr_in = mpd_pkg::ST_COUNT;
                     end
                  end
               end
               mpd_pkg::HPOS_RSVD_0,
               mpd_pkg::HPOS_RSVD_1: hdr_bad = (b != 8'd0);
               default: hdr_bad = 1'b0;
            endcase
            if (hdr_bad) begin
               ferr_in = mpd_pkg::ST_HEADER;
            end
            if (fbc_ff[2:0] == mpd_pkg::HPOS_RSVD_1) begin
               phase_in = (ferr_in == mpd_pkg::ST_OK) ? mpd_pkg::PH_SUBHDR
                                                       : mpd_pkg::PH_ERROR;
            end
         end

         mpd_pkg::PH_SUBHDR: begin
            unique case (idx_ff)
               mpd_pkg::SPOS_CHANNEL: begin
                  chan_in  = b;
                  shbad_in = (b != cfg.ctrl_channel) && (b != cfg.data_channel);
               end
               mpd_pkg::SPOS_ZERO: begin
                  if (b != 8'd0) begin
                     shbad_in = 1'b1;
                  end
               end
               mpd_pkg::SPOS_LEN_LO: lenlo_in = b;
               mpd_pkg::SPOS_LEN_HI: begin
                  // Subheader judged only once complete
                  if ((sub_len == 16'd0) || shbad_ff) begin
                     shbad_in = 1'b1;
                     if (ferr_ff == mpd_pkg::ST_OK) begin
                        ferr_in = mpd_pkg::ST_BAD_SUB;
                     end
                     phase_in = mpd_pkg::PH_ERROR;
                  end else begin
                     rem_in   = sub_len;
                     off_in   = 16'd0;
                     phase_in = mpd_pkg::PH_PAYLOAD;
                  end
               end
               default: lenlo_in = lenlo_ff;
            endcase
            idx_in = idx_ff + 2'd1;
         end

         mpd_pkg::PH_PAYLOAD: begin
            result.payload_byte  = b;
            result.payload_valid = 1'b1;
            result.channel_id    = chan_ff;
            result.sdu_number    = sdu_ff[2:0];
            result.byte_offset   = off_ff;
            result.sdu_last_byte = (rem_ff == 16'd1);
            rem_in = rem_ff - 16'd1;
            off_in = off_ff + 16'd1;
            // Last payload byte of this SDU
            if (rem_ff == 16'd1) begin
               sdu_in   = sdu_nx;
               idx_in   = 2'd0;
               shbad_in = 1'b0;
               phase_in = ({4'd0, sdu_nx} >= decl_ff) ? mpd_pkg::PH_DONE
                                                       : mpd_pkg::PH_SUBHDR;
            end
         end

         mpd_pkg::PH_DONE: begin
            // Any byte after the last SDU
            if (ferr_ff == mpd_pkg::ST_OK) begin
               ferr_in = mpd_pkg::ST_TRAILING;
            end
            phase_in = mpd_pkg::PH_ERROR;
         end

         mpd_pkg::PH_ERROR: begin
            phase_in = mpd_pkg::PH_ERROR;
         end

         default: begin
            phase_in = mpd_pkg::PH_ERROR;
         end
      endcase

      // Frame close: status, then clear for the next frame
      if (beat.frame_end) begin
         if ((fbc_in > FBC_W'(mpd_pkg::MAX_FRAME_BYTES)) ||
             (phase_in == mpd_pkg::PH_HEADER) || (ferr_in == mpd_pkg::ST_HEADER)) begin
            st = mpd_pkg::ST_HEADER;
         end else if (ferr_in != mpd_pkg::ST_OK) begin
            st = ferr_in;
         end else if (phase_in == mpd_pkg::PH_SUBHDR) begin
            st = mpd_pkg::ST_TRUNC_SUB;
         end else if (phase_in == mpd_pkg::PH_PAYLOAD) begin
            st = mpd_pkg::ST_BAD_SUB;
         end else begin
            st = mpd_pkg::ST_OK;
         end
         result.frame_done = 1'b1;
         result.status     = st;
         result.sdu_count  = (st == mpd_pkg::ST_OK) ? decl_in[3:0] : 4'd0;

         phase_in = mpd_pkg::PH_HEADER;
         fbc_in   = '0;
         decl_in  = 8'd0;
         sdu_in   = 4'd0;
         idx_in   = 2'd0;
         chan_in  = 8'd0;
         lenlo_in = 8'd0;
         rem_in   = 16'd0;
         off_in   = 16'd0;
         shbad_in = 1'b0;
         ferr_in  = mpd_pkg::ST_OK;
      end
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mpd_pkg::PH_HEADER;
         fbc_ff   <= '0;
         decl_ff  <= 8'd0;
         sdu_ff   <= 4'd0;
         idx_ff   <= 2'd0;
         chan_ff  <= 8'd0;
         lenlo_ff <= 8'd0;
         rem_ff   <= 16'd0;
         off_ff   <= 16'd0;
         shbad_ff <= 1'b0;
         ferr_ff  <= mpd_pkg::ST_OK;
      end else if (advance) begin
         phase_ff <= phase_in;
         fbc_ff   <= fbc_in;
         decl_ff  <= decl_in;
         sdu_ff   <= sdu_in;
         idx_ff   <= idx_in;
         chan_ff  <= chan_in;
         lenlo_ff <= lenlo_in;
         rem_ff   <= rem_in;
         off_ff   <= off_in;
         shbad_ff <= shbad_in;
         ferr_ff  <= ferr_in;
      end
   end

endmodule

// ===== rtl/core/mpd_out_stage.sv =====
// Result register of the MAC PDU deframer: holds one result beat for the sink.
// Depends on mpd_pkg and mpd_rsp_if.

module mpd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  mpd_pkg::rsp_beat_type result,
   output logic                  room,
   mpd_rsp_if.source             rsp_ch
);

   logic                  vld_ff;
   logic                  vld_in;
   mpd_pkg::rsp_beat_type out_ff;

   // Free when empty or when the sink takes the held beat this cycle
   assign room = !vld_ff || rsp_ch.ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid         = vld_ff;
   assign rsp_ch.payload_byte  = out_ff.payload_byte;
   assign rsp_ch.payload_valid = out_ff.payload_valid;
   assign rsp_ch.channel_id    = out_ff.channel_id;
   assign rsp_ch.sdu_number    = out_ff.sdu_number;
   assign rsp_ch.byte_offset   = out_ff.byte_offset;
   assign rsp_ch.sdu_last_byte = out_ff.sdu_last_byte;
   assign rsp_ch.frame_done    = out_ff.frame_done;
   assign rsp_ch.status        = out_ff.status;
   assign rsp_ch.sdu_count     = out_ff.sdu_count;

endmodule

// ===== rtl/core/mac_pdu_deframer.sv =====
// Top level of the MAC PDU deframer: configuration registers and the pipeline.
// Depends on mpd_pkg, mpd_ifs, mpd_in_stage, mpd_parser and mpd_out_stage.

// The deframer takes one transport-block byte per beat on req_ch and sustains
// one byte per clock while the sink keeps up. Each accepted byte is parsed
// straight out of the input register and its result is registered in the
// result register, which drives rsp_ch. A result beat is given for every
// payload byte and for the byte that carries frame_end (which also carries the
// frame status); header and subheader bytes give none. A stalled sink only
// holds up the pipeline when the parsed byte produces a result and the result
// register is still full. Status 1 (header or length) overrides all other
// errors; otherwise the first error is reported, and payload beats already
// delivered for a failed frame must be dropped by the consumer. The user must
// write csr_ registers only while the block is idle; this is not enforced.

module mac_pdu_deframer (
   input  logic                            clock,
   input  logic                            reset,
   mpd_req_if.sink                         req_ch,
   mpd_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [mpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                      csr_wdata
);

   mpd_pkg::cfg_type      cfg_ff;
   mpd_pkg::req_beat_type beat;
   mpd_pkg::rsp_beat_type result;
   logic                  beat_valid;
   logic                  emit;
   logic                  room;
   logic                  advance;
   logic                  load;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ctrl_channel <= mpd_pkg::CTRL_CHANNEL_RST;
         cfg_ff.data_channel <= mpd_pkg::DATA_CHANNEL_RST;
         cfg_ff.sdu_capacity <= mpd_pkg::SDU_CAPACITY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            mpd_pkg::CSR_CTRL_CHANNEL: cfg_ff.ctrl_channel <= csr_wdata;
            mpd_pkg::CSR_DATA_CHANNEL: cfg_ff.data_channel <= csr_wdata;
            mpd_pkg::CSR_SDU_CAPACITY: cfg_ff.sdu_capacity <= csr_wdata[3:0];
            default:                   cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Byte moves on unless it makes a result and the result register is busy
   assign advance = beat_valid && (!emit || room);
   assign load    = advance && emit;

   mpd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   mpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .beat    (beat),
      .advance (advance),
      .emit    (emit),
      .result  (result)
   );

   mpd_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .result (result),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

endmodule
